[src/stb_pkg.sv]
`default_nettype none

package stb_pkg;

   // Bank geometry
   localparam int NUM_TIMERS    = 16;
   localparam int IDX_BITS      = 4;
   localparam int DURATION_BITS = 16;

   // Field and port widths
   localparam int INTERVAL_BITS  = 16;
   localparam int PERIOD_BITS    = 10;
   localparam int PROC_PER_BITS  = 16;
   localparam int SEC_ACC_BITS   = 11;
   localparam int PROC_ACC_BITS  = 17;
   localparam int REQ_DATA_BITS  = 24;
   localparam int RSP_DATA_BITS  = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [PERIOD_BITS-1:0]   MS_PER_SECOND     = 10'd1000;
   localparam logic [PERIOD_BITS-1:0]   TICK_PERIOD_RESET = 10'd1000;
   localparam logic [PROC_PER_BITS-1:0] PROC_PERIOD_RESET = 16'd500;

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STAT_DONE       = 3'd0,
      STAT_ZERO       = 3'd1,
      STAT_ACTIVE     = 3'd2,
      STAT_NOT_ACTIVE = 3'd3,
      STAT_TICK       = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      RUN_STOPPED = 2'd0,
      RUN_RUNNING = 2'd1,
      RUN_EXPIRED = 2'd2
   } run_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TICK_PERIOD = 1'b0,
      CSR_PROC_PERIOD = 1'b1
   } csr_type;

   // Command broadcast to every cell
   typedef struct packed {
      op_type                   op;
      logic [INTERVAL_BITS-1:0] interval;
      logic                     per_second;
   } stb_cmd_type;

   // Walk control shared by the chain
   typedef struct packed {
      logic step;
      logic pass_sec;
   } stb_walk_type;

endpackage

`default_nettype wire

[src/stb_cell.sv]
`default_nettype none

module stb_cell import stb_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire stb_cmd_type  cmd,
   input  wire logic         sel,
   input  wire stb_walk_type walk,
   input  wire logic         visit_in,
   output logic              visit_out,
   output status_type        status_out,
   output logic              expire_out
);

   logic [DURATION_BITS-1:0] dur_ff, dur_in;
   logic [DURATION_BITS-1:0] cnt_ff, cnt_in;
   run_type                  run_ff, run_in;
   logic                     act_ff, act_in;
   logic                     cls_ff, cls_in;
   logic                     visit_ff;

   logic running, pre_clear, act_eff, hit;

   assign running   = (run_ff == RUN_RUNNING);
   assign pre_clear = running && act_ff;
   assign act_eff   = act_ff && !pre_clear;
   assign hit       = walk.step && visit_ff && act_ff && running && (cls_ff == walk.pass_sec);
   assign expire_out = hit && (cnt_ff == '0);
   assign visit_out  = visit_ff;

   always_comb begin
      status_out = STAT_DONE;
      if (sel) begin
         unique case (cmd.op)
            OP_START: begin
               if (dur_ff == '0) status_out = STAT_ZERO;
               else if (act_eff) status_out = STAT_ACTIVE;
            end
            OP_STOP: begin
               if (!act_ff) status_out = STAT_NOT_ACTIVE;
            end
            default: status_out = STAT_DONE;
         endcase
      end
   end

   always_comb begin
      dur_in = dur_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      act_in = act_ff;
      cls_in = cls_ff;
      if (sel) begin
         unique case (cmd.op)
            OP_SET: begin
               dur_in = DURATION_BITS'(cmd.interval);
               cls_in = cmd.per_second;
               run_in = RUN_STOPPED;
            end
            OP_START: begin
               if (pre_clear) begin
                  act_in = 1'b0;
                  run_in = RUN_STOPPED;
               end
               if (dur_ff != '0 && !act_eff) begin
                  cnt_in = dur_ff;
                  run_in = RUN_RUNNING;
                  act_in = 1'b1;
               end
            end
            OP_STOP: begin
               if (act_ff) begin
                  act_in = 1'b0;
                  run_in = RUN_STOPPED;
               end
            end
            default: ;
         endcase
      end else if (hit) begin
         if (cnt_ff == '0) begin
            act_in = 1'b0;
            run_in = RUN_EXPIRED;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff   <= '0;
         run_ff   <= RUN_STOPPED;
         act_ff   <= 1'b0;
         cls_ff   <= 1'b0;
         visit_ff <= 1'b0;
      end else begin
         dur_ff <= dur_in;
         run_ff <= run_in;
         act_ff <= act_in;
         cls_ff <= cls_in;
         if (walk.step) visit_ff <= visit_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
   end

endmodule

`default_nettype wire

[src/software_timer_bank_core.sv]
// Set, start and stop: each beat is accepted, then executed in the addressed cell.
// Tick: a visit token walks the chain of timer cells one cell a cycle unless the response
// side stalls, once for fast timers, again for per-second ones when a second is crossed.
// One expiry is held back to know which is last.
// Synchronous active-high reset: all timers stopped, marks clear, accumulators zero,
// tick period 1000 ms, protocol period 500 ms.
`default_nettype none

module software_timer_bank_core import stb_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // timer_index[3:0], interval[19:4], per_second[20], zero fill[23:21]
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,
   // op[1:0]
   input  wire logic [1:0]                req_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // status[2:0], expired_valid[3], expired_index[7:4], second_tick[8], proc_tick[9],
   // zero fill[15:10]
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,
   output logic                           rsp_tlast,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EXEC   = 4'b0010,
      S_WALK   = 4'b0100,
      S_FINISH = 4'b1000
   } fsm_state_type;

   // Control state
   fsm_state_type state_ff, state_in;
   stb_cmd_type   cmd_ff, cmd_in;
   logic [IDX_BITS-1:0] index_ff, index_in;
   logic launch_ff, launch_in;
   logic pass_sec_ff, pass_sec_in;
   logic sec_ff, sec_in;
   logic proc_ff, proc_in;
   logic pend_valid_ff, pend_valid_in;
   logic [IDX_BITS-1:0] pend_index_ff, pend_index_in;
   logic [SEC_ACC_BITS-1:0]  second_acc_ff, second_acc_in;
   logic [PROC_ACC_BITS-1:0] proc_acc_ff, proc_acc_in;
   logic [PERIOD_BITS-1:0]   tick_period_ff;
   logic [PROC_PER_BITS-1:0] proc_period_ff;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_exp_valid_ff, rsp_exp_valid_in;
   logic [IDX_BITS-1:0] rsp_exp_index_ff, rsp_exp_index_in;
   logic                rsp_sec_ff, rsp_sec_in;
   logic                rsp_proc_ff, rsp_proc_in;
   logic                rsp_last_ff, rsp_last_in;

   // Chain signals
   stb_walk_type          walk;
   logic [NUM_TIMERS-1:0] sel_vec, visit_vec, exp_vec;
   status_type            cell_status [NUM_TIMERS];
   logic [2:0]            status_or;
   logic                  sel_any, exp_any, last_visit, out_free, exec_go;
   logic [IDX_BITS-1:0]   exp_index;

   // Tick arithmetic
   logic [PERIOD_BITS-1:0]    period;
   logic [SEC_ACC_BITS:0]     sec_sum;
   logic [PROC_ACC_BITS:0]    proc_sum;
   logic                      sec_hit, proc_hit;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign exec_go    = (state_ff == S_EXEC) && out_free;

   assign walk.step     = (state_ff == S_WALK) && out_free;
   assign walk.pass_sec = pass_sec_ff;

   // The chain: the visit token enters at cell 0 and moves one cell each step
   for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
      assign sel_vec[k] = exec_go && (index_ff == IDX_BITS'(k));
      stb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd_ff),
         .sel        (sel_vec[k]),
         .walk       (walk),
         .visit_in   ((k == 0) ? launch_ff : visit_vec[(k == 0) ? 0 : k-1]),
         .visit_out  (visit_vec[k]),
         .status_out (cell_status[k]),
         .expire_out (exp_vec[k])
      );
   end

   // Only the addressed cell reports a non-zero status, and only the visited cell can expire
   always_comb begin
      status_or = '0;
      exp_index = '0;
      for (int k = 0; k < NUM_TIMERS; k++) begin
         status_or = status_or | cell_status[k];
         if (exp_vec[k]) exp_index = exp_index | IDX_BITS'(k);
      end
   end

   assign sel_any    = |sel_vec;
   assign exp_any    = |exp_vec;
   assign last_visit = walk.step && visit_vec[NUM_TIMERS-1];

   // Accumulator updates for a tick beat; a zero period counts as a full second
   assign period   = (tick_period_ff == '0) ? MS_PER_SECOND : tick_period_ff;
   assign sec_sum  = (SEC_ACC_BITS+1)'(second_acc_ff) + (SEC_ACC_BITS+1)'(period);
   assign sec_hit  = sec_sum >= (SEC_ACC_BITS+1)'(MS_PER_SECOND);
   assign proc_sum = (PROC_ACC_BITS+1)'(proc_acc_ff) + (PROC_ACC_BITS+1)'(period);
   assign proc_hit = proc_sum > (PROC_ACC_BITS+1)'(proc_period_ff);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      index_in      = index_ff;
      launch_in     = launch_ff;
      pass_sec_in   = pass_sec_ff;
      sec_in        = sec_ff;
      proc_in       = proc_ff;
      pend_valid_in = pend_valid_ff;
      pend_index_in = pend_index_ff;
      second_acc_in = second_acc_ff;
      proc_acc_in   = proc_acc_ff;

      // Drop the response once taken; hold the payload unless reloaded
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_status_in    = rsp_status_ff;
      rsp_exp_valid_in = rsp_exp_valid_ff;
      rsp_exp_index_in = rsp_exp_index_ff;
      rsp_sec_in       = rsp_sec_ff;
      rsp_proc_in      = rsp_proc_ff;
      rsp_last_in      = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in.op         = op_type'(req_tuser);
               cmd_in.interval   = req_tdata[IDX_BITS +: INTERVAL_BITS];
               cmd_in.per_second = req_tdata[IDX_BITS+INTERVAL_BITS];
               index_in          = req_tdata[IDX_BITS-1:0];
               if (op_type'(req_tuser) == OP_TICK) begin
                  sec_in        = sec_hit;
                  proc_in       = proc_hit;
                  second_acc_in = sec_hit
                                ? SEC_ACC_BITS'(sec_sum - (SEC_ACC_BITS+1)'(MS_PER_SECOND))
                                : SEC_ACC_BITS'(sec_sum);
                  proc_acc_in   = proc_hit ? '0 : PROC_ACC_BITS'(proc_sum);
                  launch_in     = 1'b1;
                  pass_sec_in   = 1'b0;
                  state_in      = S_WALK;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = sel_any ? status_type'(status_or) : STAT_NOT_ACTIVE;
               rsp_exp_valid_in = 1'b0;
               rsp_exp_index_in = '0;
               rsp_sec_in       = 1'b0;
               rsp_proc_in      = 1'b0;
               rsp_last_in      = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_WALK: begin
            if (out_free) begin
               launch_in = 1'b0;
               if (exp_any) begin
                  // A later expiry proves the held one is not the last
                  if (pend_valid_ff) begin
                     rsp_valid_in     = 1'b1;
                     rsp_status_in    = STAT_TICK;
                     rsp_exp_valid_in = 1'b1;
                     rsp_exp_index_in = pend_index_ff;
                     rsp_sec_in       = sec_ff;
                     rsp_proc_in      = proc_ff;
                     rsp_last_in      = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_index_in = exp_index;
               end
               if (last_visit) begin
                  if (sec_ff && !pass_sec_ff) begin
                     launch_in   = 1'b1;
                     pass_sec_in = 1'b1;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = STAT_TICK;
               rsp_exp_valid_in = pend_valid_ff;
               rsp_exp_index_in = pend_valid_ff ? pend_index_ff : '0;
               rsp_sec_in       = sec_ff;
               rsp_proc_in      = proc_ff;
               rsp_last_in      = 1'b1;
               pend_valid_in    = 1'b0;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         launch_ff      <= 1'b0;
         pass_sec_ff    <= 1'b0;
         pend_valid_ff  <= 1'b0;
         second_acc_ff  <= '0;
         proc_acc_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         tick_period_ff <= TICK_PERIOD_RESET;
         proc_period_ff <= PROC_PERIOD_RESET;
      end else begin
         state_ff      <= state_in;
         launch_ff     <= launch_in;
         pass_sec_ff   <= pass_sec_in;
         pend_valid_ff <= pend_valid_in;
         second_acc_ff <= second_acc_in;
         proc_acc_ff   <= proc_acc_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_type'(csr_index))
               CSR_TICK_PERIOD: tick_period_ff <= csr_data[PERIOD_BITS-1:0];
               CSR_PROC_PERIOD: proc_period_ff <= csr_data[PROC_PER_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_in_hold: begin
         cmd_ff           <= cmd_in;
         index_ff         <= index_in;
         sec_ff           <= sec_in;
         proc_ff          <= proc_in;
         pend_index_ff    <= pend_index_in;
         rsp_status_ff    <= rsp_status_in;
         rsp_exp_valid_ff <= rsp_exp_valid_in;
         rsp_exp_index_ff <= rsp_exp_index_in;
         rsp_sec_ff       <= rsp_sec_in;
         rsp_proc_ff      <= rsp_proc_in;
         rsp_last_ff      <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS-10)'(0), rsp_proc_ff, rsp_sec_ff, rsp_exp_index_ff,
                        rsp_exp_valid_ff, rsp_status_ff};

   // At most one cell is visited, so at most one expiry per cycle
   a_one_expiry: assert property (@(posedge clock) disable iff (reset)
      $onehot0(exp_vec))
      else $error("more than one timer expired in one cycle");

   // At most one visit token lives in the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0({launch_ff, visit_vec}))
      else $error("visit token duplicated");

   // A held expiry exists only while a tick is being walked or finished
   a_pend_scope: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_EXEC) |-> !pend_valid_ff)
      else $error("held expiry outside a tick");

   // An expiry is only ever reported by a tick beat
   a_exp_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_exp_valid_ff) |-> (rsp_status_ff == STAT_TICK))
      else $error("expiry on a non-tick response");

   // The token holds while the response side stalls
   a_walk_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && !out_free) |=> $stable(visit_vec))
      else $error("token moved during a stall");

endmodule

`default_nettype wire

[tb/sv/software_timer_bank_core_tb.sv]
module software_timer_bank_core_tb;
   import stb_pkg::*;

   // One command beat as queued for the driver
   typedef struct packed {
      op_type                   op;
      logic [IDX_BITS-1:0]      idx;
      logic [INTERVAL_BITS-1:0] interval;
      logic                     per_sec;
   } bank_cmd_type;

   // One response beat as the bank should send it
   typedef struct {
      status_type          status;
      logic                fired;
      logic [IDX_BITS-1:0] fired_idx;
      logic                sec_flag;
      logic                proc_flag;
      logic                last;
   } bank_rsp_type;

   // Receiver back-pressure styles
   typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_style_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // timer_index[3:0], interval[19:4], per_second[20], zero fill[23:21]
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   // op[1:0]
   logic [1:0]                req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // status[2:0], expired_valid[3], expired_index[7:4], second_tick[8], proc_tick[9],
   // zero fill[15:10]
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   software_timer_bank_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Generous ceiling on the whole run
   initial begin
      #3_000_000;
      $display("software_timer_bank_core: mismatch");
      $finish;
   end

   // ------------------------------------------------------------------
   // Shadow of the timer bank, advanced once per accepted command beat
   // ------------------------------------------------------------------
   int        bank_duration [NUM_TIMERS];
   int        bank_countdown[NUM_TIMERS];
   run_type   bank_run      [NUM_TIMERS] = '{default: RUN_STOPPED};
   bit        bank_active   [NUM_TIMERS];
   bit        bank_per_sec  [NUM_TIMERS];
   int        sec_acc_ms;
   int        proc_acc_ms;
   int        tick_ms = TICK_PERIOD_RESET;
   int        proc_ms = PROC_PERIOD_RESET;

   bank_cmd_type queued_cmds[$];
   bank_rsp_type awaited_rsp[$];
   int           mismatches;
   int           cmds_offered;
   int           cmds_accepted;

   // Walk one class in index order; a countdown that drops below zero expires its timer
   task automatic countdown_class(bit per_sec, ref int fired[$]);
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (bank_active[i] && bank_per_sec[i] == per_sec && bank_run[i] == RUN_RUNNING) begin
            bank_countdown[i]--;
            if (bank_countdown[i] < 0) begin
               bank_active[i] = 1'b0;
               bank_run[i]    = RUN_EXPIRED;
               fired.push_back(i);
            end
         end
      end
   endtask

   task automatic advance_timer_bank(op_type op, logic [IDX_BITS-1:0] idx,
                                     logic [INTERVAL_BITS-1:0] interval, logic per_sec);
      int           fired[$];
      int           period;
      bank_rsp_type r;
      r.status    = STAT_DONE;
      r.fired     = 1'b0;
      r.fired_idx = '0;
      r.sec_flag  = 1'b0;
      r.proc_flag = 1'b0;
      r.last      = 1'b1;
      case (op)
         OP_TICK: begin
            // A zero tick period stands for a full second
            period = (tick_ms != 0) ? tick_ms : 1000;
            sec_acc_ms  += period;
            proc_acc_ms += period;
            countdown_class(1'b0, fired);
            if (proc_acc_ms > proc_ms) begin
               r.proc_flag = 1'b1;
               proc_acc_ms = 0;
            end
            if (sec_acc_ms >= 1000) begin
               r.sec_flag = 1'b1;
               countdown_class(1'b1, fired);
               sec_acc_ms -= 1000;
            end
            sec_acc_ms  &= (1 << SEC_ACC_BITS) - 1;
            proc_acc_ms &= (1 << PROC_ACC_BITS) - 1;
            r.status = STAT_TICK;
            if (fired.size() == 0) begin
               awaited_rsp.push_back(r);
            end else begin
               r.fired = 1'b1;
               foreach (fired[k]) begin
                  r.fired_idx = IDX_BITS'(fired[k]);
                  r.last      = (k == fired.size() - 1);
                  awaited_rsp.push_back(r);
               end
            end
         end
         OP_SET: begin
            // Active mark survives a set, which is what makes "already active" reachable
            bank_duration[idx] = interval;
            bank_per_sec[idx]  = per_sec;
            bank_run[idx]      = RUN_STOPPED;
            awaited_rsp.push_back(r);
         end
         OP_START: begin
            if (bank_run[idx] == RUN_RUNNING && bank_active[idx]) begin
               bank_active[idx] = 1'b0;
               bank_run[idx]    = RUN_STOPPED;
            end
            if (bank_duration[idx] == 0) begin
               r.status = STAT_ZERO;
            end else if (bank_active[idx]) begin
               r.status = STAT_ACTIVE;
            end else begin
               bank_countdown[idx] = bank_duration[idx];
               bank_run[idx]       = RUN_RUNNING;
               bank_active[idx]    = 1'b1;
            end
            awaited_rsp.push_back(r);
         end
         default: begin
            if (!bank_active[idx]) begin
               r.status = STAT_NOT_ACTIVE;
            end else begin
               bank_active[idx] = 1'b0;
               bank_run[idx]    = RUN_STOPPED;
            end
            awaited_rsp.push_back(r);
         end
      endcase
   endtask

   task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // ------------------------------------------------------------------
   // Monitor: sample every handshake at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      bank_rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TICK_PERIOD: tick_ms = csr_data[PERIOD_BITS-1:0];
               CSR_PROC_PERIOD: proc_ms = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            advance_timer_bank(op_type'(req_tuser), req_tdata[3:0], req_tdata[19:4],
                               req_tdata[20]);
            cmds_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: response beat expected none, actual tdata %h tlast %b",
                        $time, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = awaited_rsp.pop_front();
               compare_field("status",        want.status,    rsp_tdata[2:0]);
               compare_field("expired_valid", want.fired,     rsp_tdata[3]);
               compare_field("expired_index", want.fired_idx, rsp_tdata[7:4]);
               compare_field("second_tick",   want.sec_flag,  rsp_tdata[8]);
               compare_field("proc_tick",     want.proc_flag, rsp_tdata[9]);
               compare_field("tlast",         want.last,      rsp_tlast);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Driver: bursts of command beats with random gaps, changed on the falling edge
   // ------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(negedge clock) begin
      bank_cmd_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && cmds_accepted != cmds_offered) begin
         // hold the beat until the bank takes it
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (queued_cmds.size() == 0) begin
         req_tvalid <= 1'b0;
      end else begin
         c = queued_cmds.pop_front();
         req_tvalid <= 1'b1;
         req_tuser  <= c.op;
         req_tdata  <= {3'b000, c.per_sec, c.interval, c.idx};
         cmds_offered++;
         if (burst_left <= 1) begin
            // a quarter of bursts run straight into the next one
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: back-pressure whose style is redrawn at random whenever its random-length span runs out
   // ------------------------------------------------------------------
   rx_style_type rx_style = RX_OPEN;
   int           rx_span;
   int           rx_phase;
   int           rx_hold;

   always @(negedge clock) begin
      bit ready_next;
      if (rx_span == 0) begin
         rx_style = rx_style_type'($urandom_range(0, 3));
         rx_span  = $urandom_range(50, 300);
      end
      rx_span--;
      rx_phase++;
      case (rx_style)
         RX_OPEN:     ready_next = 1'b1;
         RX_COIN:     ready_next = 1'($urandom_range(0, 1));
         RX_PERIODIC: ready_next = (rx_phase % 5) > 1;
         default: begin
            if (rx_hold > 0) begin
               rx_hold--;
               ready_next = 1'b0;
            end else begin
               ready_next = 1'b1;
               if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(3, 12);
            end
         end
      endcase
      rsp_tready <= ready_next;
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   function automatic void queue_cmd(op_type op, int idx, int interval, int per_sec);
      bank_cmd_type c;
      c.op       = op;
      c.idx      = IDX_BITS'(idx);
      c.interval = INTERVAL_BITS'(interval);
      c.per_sec  = 1'(per_sec);
      queued_cmds.push_back(c);
   endfunction

   // Mostly short durations so that timers actually expire; now and then the full range
   function automatic int pick_interval();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6)  return $urandom_range(1, 4);
      if (r == 6) return 0;
      if (r < 9)  return $urandom_range(5, 30);
      return $urandom_range(0, 65535);
   endfunction

   // Mostly set-then-start pairs and ticks, with loose starts, stops and sets as noise
   task automatic queue_random_traffic(int count);
      int n;
      int idx;
      int r;
      n = 0;
      while (n < count) begin
         r   = $urandom_range(0, 9);
         idx = $urandom_range(0, NUM_TIMERS - 1);
         if (r < 3) begin
            queue_cmd(OP_SET, idx, pick_interval(), $urandom_range(0, 1));
            queue_cmd(OP_START, idx, $urandom_range(0, 65535), $urandom_range(0, 1));
            n += 2;
         end else begin
            if (r < 7)
               queue_cmd(OP_TICK, idx, $urandom_range(0, 65535), $urandom_range(0, 1));
            else if (r == 7)
               queue_cmd(OP_START, idx, $urandom_range(0, 65535), $urandom_range(0, 1));
            else if (r == 8)
               queue_cmd(OP_STOP, idx, $urandom_range(0, 65535), $urandom_range(0, 1));
            else
               queue_cmd(OP_SET, idx, pick_interval(), $urandom_range(0, 1));
            n++;
         end
      end
   endtask

   // Wait for the bank to drain, then give a tick walk time to finish
   task automatic settle_bank();
      do @(posedge clock);
      while (queued_cmds.size() != 0 || req_tvalid || awaited_rsp.size() != 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(csr_type which, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Write both registers in random order, then run a stretch of traffic
   task automatic run_phase(logic [PERIOD_BITS-1:0] tick, logic [PROC_PER_BITS-1:0] proc,
                            int count);
      settle_bank();
      if ($urandom_range(0, 1)) begin
         write_csr(CSR_TICK_PERIOD, CSR_DATA_BITS'(tick));
         write_csr(CSR_PROC_PERIOD, proc);
      end else begin
         write_csr(CSR_PROC_PERIOD, proc);
         write_csr(CSR_TICK_PERIOD, CSR_DATA_BITS'(tick));
      end
      queue_random_traffic(count);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset periods: every tick crosses a second and
      // raises the protocol flag.
      queue_cmd(OP_SET,   0, 0, 1'b0);           // zero duration
      queue_cmd(OP_START, 0, 0, 1'b0);           // start refused: zero duration
      queue_cmd(OP_STOP,  0, 0, 1'b0);           // stop refused: not active
      queue_cmd(OP_SET,  15, 65535, 1'b1);       // top index, longest duration
      queue_cmd(OP_START,15, 0, 1'b0);
      queue_cmd(OP_SET,  15, 65535, 1'b1);       // set while it runs keeps the mark
      queue_cmd(OP_START,15, 0, 1'b0);           // start refused: already active
      queue_cmd(OP_STOP, 15, 0, 1'b0);
      queue_cmd(OP_SET,   1, 1, 1'b0);
      queue_cmd(OP_START, 1, 0, 1'b0);
      queue_cmd(OP_START, 1, 0, 1'b0);           // restart of a running timer
      queue_cmd(OP_SET,   2, 1, 1'b1);
      queue_cmd(OP_START, 2, 0, 1'b0);
      queue_cmd(OP_SET,   3, 2, 1'b0);
      queue_cmd(OP_START, 3, 0, 1'b0);
      queue_cmd(OP_TICK,  0, 0, 1'b0);
      queue_cmd(OP_TICK,  0, 0, 1'b0);           // fast 1 reported ahead of per-second 2
      queue_cmd(OP_TICK,  0, 0, 1'b0);           // timer 3 expires alone
      queue_cmd(OP_TICK, 15, 65535, 1'b1);       // nothing left to expire
      queue_cmd(OP_START, 1, 0, 1'b0);           // restart after expiry
      queue_cmd(OP_STOP,  1, 0, 1'b0);
      queue_cmd(OP_SET,  10, 16'hAAAA, 1'b0);
      queue_cmd(OP_SET,   5, 16'h5555, 1'b1);

      // Zero tick period stands for a second; zero protocol period flags every tick
      run_phase(10'd0, 16'd0, 10);

      // Whole bank expiring on one tick: every timer short, both classes mixed
      settle_bank();
      for (int i = 0; i < NUM_TIMERS; i++) begin
         queue_cmd(OP_SET, i, 1, $urandom_range(0, 1));
         queue_cmd(OP_START, i, 0, 1'b0);
      end
      repeat (3) queue_cmd(OP_TICK, 0, 0, 1'b0);

      // Shortest tick and longest protocol period, then the widest tick period
      run_phase(10'd1, 16'hFFFF, 10);
      run_phase(10'd1023, 16'd1, 10);
      run_phase(10'd250, 16'd700, 10);
      run_phase(PERIOD_BITS'($urandom_range(1, 1000)), PROC_PER_BITS'($urandom_range(0, 3000)),
                10);
      run_phase(TICK_PERIOD_RESET, PROC_PERIOD_RESET, 10);

      settle_bank();
      if (awaited_rsp.size() != 0) begin
         $display("%0t: %0d response beats expected, actual none", $time, awaited_rsp.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("software_timer_bank_core: match");
      else
         $display("software_timer_bank_core: mismatch");
      $finish;
   end

endmodule
